@@ design/rdsm_pkg.sv @@
package rdsm_pkg;

  // Default depth of the pattern store
  localparam int MAX_TOKENS_DEF = 16;

  // Field widths of the item
  localparam int INDEX_W  = 4;
  localparam int CHAR_W   = 8;
  localparam int LENGTH_W = 5;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 8;

  // Item kinds carried in s_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // One pattern token: a literal byte or a dot, optionally starred
  typedef struct packed {
    logic              star;
    logic              any;
    logic [CHAR_W-1:0] char_val;
  } token_t;

endpackage

@@ design/rdsm_nfa_step.sv @@
module rdsm_nfa_step #(
  parameter int MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEF
) (
  input  logic [MAX_TOKENS:0]                      active,
  input  rdsm_pkg::token_t [MAX_TOKENS-1:0]        tokens,
  input  logic [rdsm_pkg::LENGTH_W-1:0]            pattern_length,
  input  logic [rdsm_pkg::CHAR_W-1:0]              text_char,
  input  logic                                     text_valid,
  output logic [MAX_TOKENS:0]                      active_next,
  output logic                                     matched
);

  logic [MAX_TOKENS:0]   en;       // position lies within the pattern
  logic [MAX_TOKENS:0]   end_pos;  // position is the pattern end
  logic [MAX_TOKENS:0]   closed;
  logic [MAX_TOKENS:0]   raw;
  logic [MAX_TOKENS:0]   stepped;
  logic [MAX_TOKENS-1:0] hit;

  // Position masks; a length beyond the store acts as the full store
  always_comb begin
    for (int k = 0; k <= MAX_TOKENS; k++) begin
      en[k]      = (k <= int'(pattern_length));
      end_pos[k] = (k == int'(pattern_length)) ||
                   ((k == MAX_TOKENS) && (int'(pattern_length) > MAX_TOKENS));
    end
  end

  // Closure of the held set across starred tokens under the current pattern
  always_comb begin
    closed[0] = active[0];
    for (int k = 1; k <= MAX_TOKENS; k++) begin
      closed[k] = en[k] & (active[k] | (closed[k-1] & tokens[k-1].star));
    end
  end

  // Consume one byte: starred tokens stay put, others advance
  always_comb begin
    raw = '0;
    for (int k = 0; k < MAX_TOKENS; k++) begin
      hit[k] = tokens[k].any || (tokens[k].char_val == text_char);
      if (en[k+1] && closed[k] && hit[k]) begin
        if (tokens[k].star) begin
          raw[k] = 1'b1;
        end else begin
          raw[k+1] = 1'b1;
        end
      end
    end
  end

  // Closure after the step
  always_comb begin
    stepped[0] = raw[0];
    for (int k = 1; k <= MAX_TOKENS; k++) begin
      stepped[k] = en[k] & (raw[k] | (stepped[k-1] & tokens[k-1].star));
    end
  end

  assign active_next = text_valid ? stepped : closed;
  assign matched     = |(active_next & end_pos);

endmodule

@@ design/regex_dot_star_matcher_unit.sv @@
// Whole-text matcher for patterns of literal bytes and dots, each optionally
// starred. Usage:
//   - Write the token count on cfg_we/cfg_wdata while the block is idle.
//   - Load tokens with s_tuser = load (index, byte, dot and star flags in
//     s_tdata); loads give no result.
//   - Stream text items with s_tuser = text; s_tlast marks the final item of
//     the text. An item without a byte (text_valid low) and s_tlast high
//     checks the empty text.
//   - One result item (match flag in m_tdata[0]) comes out per text.
// A final text item is taken into the input register and then into the
// result register, whose valid flag drives m_tvalid.
// Throughput: one item per cycle while s_tready is high; the set of active
// positions is updated by a single pass of parallel closure and step logic
// between the input register and the state/result registers.
// Reset clears the token count and sets the active set to the start position;
// the pattern store holds no value until loaded.
// When m_tready is low a pending result holds; the input register keeps
// accepting loads and non-final text items, and s_tready drops only when a
// final text item waits behind an untaken result.
module regex_dot_star_matcher_unit #(
  parameter int MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration: token count in use
  input  logic                               cfg_we,
  input  logic [rdsm_pkg::LENGTH_W-1:0]      cfg_wdata,
  // Input items
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // token_index[3:0], token_char[11:4], token_any[12], token_star[13],
  // text_char[21:14], text_valid[22], zero[23]
  input  logic [rdsm_pkg::S_DATA_W-1:0]      s_tdata,
  input  logic                               s_tuser,  // op[0]
  input  logic                               s_tlast,  // text_last
  // Result items
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rdsm_pkg::M_DATA_W-1:0]      m_tdata   // matched[0], zero[7:1]
);

  // Input register
  logic                              s1_valid;
  logic                              s1_op;
  logic [rdsm_pkg::INDEX_W-1:0]      s1_index;
  logic [rdsm_pkg::CHAR_W-1:0]       s1_tok_char;
  logic                              s1_tok_any;
  logic                              s1_tok_star;
  logic [rdsm_pkg::CHAR_W-1:0]       s1_text_char;
  logic                              s1_text_valid;
  logic                              s1_last;
  logic                              s1_fire;
  logic                              s1_result;

  // State
  logic [rdsm_pkg::LENGTH_W-1:0]     pattern_length;
  rdsm_pkg::token_t [MAX_TOKENS-1:0] tokens;
  logic [MAX_TOKENS:0]               active;
  logic [MAX_TOKENS:0]               active_next;
  logic [MAX_TOKENS:0]               start_set;
  logic                              step_matched;

  // Result register
  logic                              out_valid;
  logic                              out_matched;

  assign start_set = {{MAX_TOKENS{1'b0}}, 1'b1};

  // Handshake: a final text item needs room in the result register
  assign s1_result = (s1_op == rdsm_pkg::OP_TEXT) && s1_last;
  assign s1_fire   = s1_valid && (!s1_result || !out_valid || m_tready);
  assign s_tready  = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_op         <= s_tuser;
      s1_index      <= s_tdata[3:0];
      s1_tok_char   <= s_tdata[11:4];
      s1_tok_any    <= s_tdata[12];
      s1_tok_star   <= s_tdata[13];
      s1_text_char  <= s_tdata[21:14];
      s1_text_valid <= s_tdata[22];
      s1_last       <= s_tlast;
    end
  end

  // Token count register
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
    end else if (cfg_we) begin
      pattern_length <= cfg_wdata;
    end
  end

  // Pattern store; an index past the store is dropped
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      if (s1_fire && (s1_op == rdsm_pkg::OP_LOAD) && (int'(s1_index) == k)) begin
        tokens[k].char_val <= s1_tok_char;
        tokens[k].any      <= s1_tok_any;
        tokens[k].star     <= s1_tok_star;
      end
    end
  end

  rdsm_nfa_step #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_step (
    .active         (active),
    .tokens         (tokens),
    .pattern_length (pattern_length),
    .text_char      (s1_text_char),
    .text_valid     (s1_text_valid),
    .active_next    (active_next),
    .matched        (step_matched)
  );

  // Active set: back to the start after the final item of a text
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= start_set;
    end else if (s1_fire && (s1_op == rdsm_pkg::OP_TEXT)) begin
      active <= s1_last ? start_set : active_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      out_matched <= step_matched;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(rdsm_pkg::M_DATA_W-1){1'b0}}, out_matched};

endmodule
